// File: hdl/aesm_pkg.sv
// ============================================================================
// aesm_pkg
// Shared constants, tables and round functions for the AES block mode engine.
// ============================================================================
`default_nettype none

package aesm_pkg;

  // key size limit and round key storage
  localparam int MAX_KEY_BITS = 256;
  localparam int MAX_NK       = MAX_KEY_BITS / 32;
  localparam int RK_ROWS      = MAX_NK + 7;
  localparam int RK_AW        = $clog2(RK_ROWS);

  // register indexes
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IVH  = 3'd4;
  localparam logic [2:0] REG_IVL  = 3'd5;
  localparam logic [2:0] REG_KLEN = 3'd6;
  localparam logic [2:0] REG_MODE = 3'd7;

  // chaining kinds
  localparam logic [1:0] KIND_ECB = 2'd0;
  localparam logic [1:0] KIND_CBC = 2'd1;
  localparam logic [1:0] KIND_CTR = 2'd2;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // words per key for a key_length code, limited by the key size bound
  function automatic logic [3:0] key_nk(input logic [1:0] klen);
    logic [3:0] n;
    n = (klen == 2'd3) ? 4'd8 : 4'(4 + 2 * klen);
    if (n > 4'(MAX_NK)) n = n - 4'd2;
    if (n > 4'(MAX_NK)) n = n - 4'd2;
    return n;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // one forward round: sub bytes, shift rows, mix columns unless last, add key
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] o;
    for (int k = 0; k < 16; k++) b[k] = SBOX[s[127-8*k -: 8]];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[w+4*c] = b[w+4*((c+w)&3)];
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int w = 0; w < 4; w++) o[127-8*(4*c+w) -: 8] = t[4*c+w];
      end else begin
        o[127-8*(4*c)   -: 8] = xt(t[4*c]) ^ xt(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
        o[127-8*(4*c+1) -: 8] = t[4*c] ^ xt(t[4*c+1]) ^ xt(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
        o[127-8*(4*c+2) -: 8] = t[4*c] ^ t[4*c+1] ^ xt(t[4*c+2]) ^ xt(t[4*c+3]) ^ t[4*c+3];
        o[127-8*(4*c+3) -: 8] = xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xt(t[4*c+3]);
      end
    end
    return o ^ rk;
  endfunction

  // one inverse round: inv shift rows, inv sub bytes, add key, inv mix unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [7:0] x2, x4, x8;
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) t[w+4*((c+w)&3)] = s[127-8*(w+4*c) -: 8];
    for (int k = 0; k < 16; k++) a[k] = INV_SBOX[t[k]] ^ rk[127-8*k -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        x2 = xt(a[4*c+w]);
        x4 = xt(x2);
        x8 = xt(x4);
        m9[w]  = x8 ^ a[4*c+w];
        m11[w] = x8 ^ x2 ^ a[4*c+w];
        m13[w] = x8 ^ x4 ^ a[4*c+w];
        m14[w] = x8 ^ x4 ^ x2;
      end
      if (last) begin
        for (int w = 0; w < 4; w++) o[127-8*(4*c+w) -: 8] = a[4*c+w];
      end else begin
        o[127-8*(4*c)   -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
        o[127-8*(4*c+1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
        o[127-8*(4*c+2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
        o[127-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hdl/aesm_key_store.sv
// ============================================================================
// aesm_key_store
// Key schedule sequencer and round key memory, one schedule word per cycle.
// ============================================================================
`default_nettype none

module aesm_key_store
  import aesm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [3:0][63:0]         key_word,
  input  wire logic [3:0]               nk,
  output logic                          busy,
  input  wire logic [RK_AW-1:0]         raddr,
  output logic [127:0]                  rdata
);

  logic [127:0]  rk_mem [RK_ROWS];
  logic [5:0]    idx;
  logic [3:0]    pos;
  logic [7:0]    rcon;
  logic [31:0]   win [8];
  logic [95:0]   row_buf;
  logic [31:0]   t;
  logic [31:0]   w_new;
  logic [63:0]   kw;
  logic [5:0]    last_idx;

  assign last_idx = 6'(4 * nk + 27);

  // next schedule word
  always_comb begin
    kw = key_word[idx[2:1]];
    t  = win[7];
    if (pos == 4'd0) begin
      t = sub_word({win[7][23:0], win[7][31:24]}) ^ {rcon, 24'h0};
    end else if (nk > 4'd6 && pos == 4'd4) begin
      t = sub_word(win[7]);
    end
    if (idx < 6'(nk)) begin
      w_new = idx[0] ? kw[31:0] : kw[63:32];
    end else begin
      w_new = win[3'(4'd8 - nk)] ^ t;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      pos  <= '0;
      rcon <= 8'h01;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      pos  <= '0;
      rcon <= 8'h01;
    end else if (busy) begin
      idx <= idx + 6'd1;
      pos <= (pos == nk - 4'd1) ? 4'd0 : pos + 4'd1;
      if (idx >= 6'(nk) && pos == 4'd0) rcon <= xt(rcon);
      if (idx == last_idx) busy <= 1'b0;
    end
  end

  // word window and row assembly
  always_ff @(posedge clk) begin
    if (busy) begin
      for (int k = 0; k < 7; k++) win[k] <= win[k+1];
      win[7]  <= w_new;
      row_buf <= {row_buf[63:0], w_new};
      if (idx[1:0] == 2'd3) rk_mem[idx[RK_AW+1:2]] <= {row_buf, w_new};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= rk_mem[raddr];
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("key schedule restarted while busy");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last_idx) else $error("key schedule index past end");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    busy && !start && idx == last_idx |=> !busy) else $error("key schedule did not stop");
`endif

endmodule

`default_nettype wire

// File: hdl/aes_block_mode_engine_core.sv
// ============================================================================
// aes_block_mode_engine_core
// AES-128/192/256 in ECB, CBC or CTR mode, one 128-bit block per item.
// ============================================================================
// One item at a time. An item passes through one round key memory read setup,
// the initial key add, one pass per round through the shared round unit, and
// the output state. After reset or after a write to a key register or
// key_length that does not coincide with the acceptance of an item, the next
// item first runs the key schedule, one word per cycle into the round key
// memory, and then hands off to the read setup.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module aes_block_mode_engine_core
  import aesm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [63:0]  block_high,
  input  wire logic [63:0]  block_low,
  input  wire logic [4:0]   bytes_valid,
  input  wire logic         first_block,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [63:0]       result_high,
  output logic [63:0]       result_low
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPAND = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_KEY0   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [3:0][63:0] key_word;
  logic [63:0]      iv_high, iv_low;
  logic [1:0]       key_length;
  logic [2:0]       cipher_mode;
  logic             dirty;
  logic [127:0]     chain;
  logic [63:0]      counter;

  logic [2:0]       state;
  logic [127:0]     st;
  logic [127:0]     aux;
  logic             op_dec, op_cbce;
  logic [RK_AW-1:0] krow, raddr, nr_row;
  logic [3:0]       nk;
  logic             ks_busy;
  logic [127:0]     rk_q;

  logic             wr, accept, last, out_free;
  logic             dec;
  logic [1:0]       kind;
  logic [4:0]       nv;
  logic [127:0]     blk_raw, blk, chain_eff, ctr_blk;
  logic [63:0]      ctr_eff;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign nk       = key_nk(key_length);
  assign nr_row   = RK_AW'(nk + 4'd6);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word    <= '0;
      iv_high     <= '0;
      iv_low      <= '0;
      key_length  <= '0;
      cipher_mode <= '0;
    end else if (wr) begin
      case (paddr[5:3])
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[paddr[4:3]] <= pwdata;
        REG_IVH:  iv_high     <= pwdata;
        REG_IVL:  iv_low      <= pwdata;
        REG_KLEN: key_length  <= pwdata[1:0];
        REG_MODE: cipher_mode <= pwdata[2:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: prdata = key_word[paddr[4:3]];
      REG_IVH:  prdata = iv_high;
      REG_IVL:  prdata = iv_low;
      REG_KLEN: prdata = {62'h0, key_length};
      REG_MODE: prdata = {61'h0, cipher_mode};
      default:  prdata = '0;
    endcase
  end

  // item decode: masking, chaining value and counter block
  always_comb begin
    dec  = cipher_mode[0];
    kind = (cipher_mode[2:1] == 2'd3) ? KIND_ECB : cipher_mode[2:1];
    nv   = (bytes_valid > 5'd16) ? 5'd16 : bytes_valid;
    blk_raw = {block_high, block_low};
    for (int k = 0; k < 16; k++) begin
      blk[127-8*k -: 8] = (dec || 5'(k) < nv) ? blk_raw[127-8*k -: 8] : 8'h00;
    end
    chain_eff = first_block ? {iv_high, iv_low} : chain;
    ctr_eff   = first_block ? 64'h0 : counter;
    ctr_blk[127:64] = iv_high;
    for (int k = 0; k < 8; k++) ctr_blk[63-8*k -: 8] = ctr_eff[8*k +: 8];
  end

  assign last = op_dec ? (krow == '0) : (krow == nr_row);

  // round key read address
  always_comb begin
    raddr = krow;
    case (state)
      S_LOAD:  raddr = op_dec ? nr_row : '0;
      S_KEY0, S_ROUND: begin
        if (!last) raddr = op_dec ? krow - 1'b1 : krow + 1'b1;
      end
      default: raddr = krow;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dirty     <= 1'b1;
      out_valid <= 1'b0;
      chain     <= '0;
      counter   <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      if (wr && !accept && (paddr[5:3] == REG_KEY0 || paddr[5:3] == REG_KEY1 ||
                            paddr[5:3] == REG_KEY2 || paddr[5:3] == REG_KEY3 ||
                            paddr[5:3] == REG_KLEN)) begin
        dirty <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            chain   <= (kind == KIND_CBC && dec) ? blk_raw : chain_eff;
            counter <= (kind == KIND_CTR) ? ctr_eff + 64'd1 : ctr_eff;
            dirty   <= 1'b0;
            state   <= dirty ? S_EXPAND : S_LOAD;
          end
        end
        S_EXPAND: if (!ks_busy) state <= S_LOAD;
        S_LOAD:   state <= S_KEY0;
        S_KEY0:   state <= S_ROUND;
        S_ROUND:  if (last) state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (op_cbce) chain <= st;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // cipher datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_dec  <= dec && kind != KIND_CTR;
          op_cbce <= !dec && kind == KIND_CBC;
          case (kind)
            KIND_CBC: st <= dec ? blk : blk ^ chain_eff;
            KIND_CTR: st <= ctr_blk;
            default:  st <= blk;
          endcase
          aux <= (kind == KIND_CTR) ? blk : ((kind == KIND_CBC && dec) ? chain_eff : '0);
        end
      end
      S_LOAD: krow <= raddr;
      S_KEY0: begin
        st   <= st ^ rk_q;
        krow <= raddr;
      end
      S_ROUND: begin
        st   <= op_dec ? dec_round(st, rk_q, last) : enc_round(st, rk_q, last);
        krow <= raddr;
      end
      S_FIN: begin
        if (out_free) begin
          {result_high, result_low} <= st ^ aux;
        end
      end
      default: ;
    endcase
  end

  aesm_key_store u_key_store (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && dirty),
    .key_word (key_word),
    .nk       (nk),
    .busy     (ks_busy),
    .raddr    (raddr),
    .rdata    (rk_q)
  );

`ifndef SYNTHESIS
  a_expand_on_dirty: assert property (@(posedge clk) disable iff (rst)
    accept && dirty |=> state == S_EXPAND) else $error("stale round keys used");
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> krow <= nr_row) else $error("round key row out of range");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_free |=> out_valid && state == S_IDLE)
    else $error("result not delivered");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !out_ready |=> state == S_FIN)
    else $error("result overwritten");
`endif

endmodule

`default_nettype wire

// File: test/tb_aes_block_mode_engine_core.sv
// ----------------------------------------------------------------------------
// tb_aes_block_mode_engine_core
// Self-checking bench for the AES block mode engine. A behavioral AES model in
// the bench follows ECB, CBC and CTR chaining for every key size, checks each
// result block against it, and keeps going after a mismatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_aes_block_mode_engine_core;
  import aesm_pkg::*;

  // cipher_mode codes
  localparam logic [2:0] MODE_ECB_ENC = 3'd0;
  localparam logic [2:0] MODE_ECB_DEC = 3'd1;
  localparam logic [2:0] MODE_CBC_ENC = 3'd2;
  localparam logic [2:0] MODE_CBC_DEC = 3'd3;
  localparam logic [2:0] MODE_CTR_ENC = 3'd4;
  localparam logic [2:0] MODE_CTR_DEC = 3'd5;
  localparam logic [2:0] MODE_ALT_ENC = 3'd6;
  localparam logic [2:0] MODE_ALT_DEC = 3'd7;

  // key_length codes
  localparam logic [1:0] KLEN_128   = 2'd0;
  localparam logic [1:0] KLEN_192   = 2'd1;
  localparam logic [1:0] KLEN_256   = 2'd2;
  localparam logic [1:0] KLEN_ALIAS = 2'd3;

  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [63:0] block_high, block_low;
  logic [4:0]  bytes_valid;
  logic        first_block;
  logic        out_valid, out_ready;
  logic [63:0] result_high, result_low;

  aes_block_mode_engine_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_high(block_high), .block_low(block_low),
    .bytes_valid(bytes_valid), .first_block(first_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low)
  );

  always #5 clk = ~clk;

  // model copy of registers and chaining state
  logic [63:0] m_key [4];
  logic [63:0] m_iv_hi, m_iv_lo;
  logic [1:0]  m_klen;
  logic [2:0]  m_mode;
  logic [63:0] m_chain_hi, m_chain_lo;
  logic [63:0] m_counter;
  logic [31:0] sched [60];
  logic [7:0]  fwd_tab [256];
  logic [7:0]  inv_tab [256];

  block_t pending_results [$];
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  // S-box from the field inverse walk
  task automatic build_sub_tables();
    logic [7:0] p, q, rl;
    p = 8'h01;
    q = 8'h01;
    fwd_tab[0] = 8'h63;
    do begin
      p = p ^ gf_dbl(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      rl = q;
      for (int k = 1; k <= 4; k++) rl ^= (q << k) | (q >> (8 - k));
      fwd_tab[p] = rl ^ 8'h63;
    end while (p != 8'h01);
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = 8'(i);
  endtask

  // key schedule into sched, returns round count
  function automatic int build_schedule();
    int nk, total;
    logic [7:0]  rc;
    logic [31:0] t;
    nk = (m_klen == KLEN_ALIAS) ? 8 : 4 + 2 * m_klen;
    while (nk * 32 > MAX_KEY_BITS && nk > 4) nk -= 2;
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? m_key[i/2][31:0] : m_key[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
        t[31:24] ^= rc;
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
      end
      sched[i] = sched[i-nk] ^ t;
    end
    return nk + 6;
  endfunction

  function automatic logic [127:0] rkey(input int r);
    return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] s, input int nr);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    s ^= rkey(0);
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) b[i] = fwd_tab[s[127-8*i -: 8]];
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) t[w+4*c] = b[w+4*((c+w)%4)];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        if (r != nr) begin
          t[4*c]   = gf_dbl(a0 ^ a1) ^ a1 ^ a2 ^ a3;
          t[4*c+1] = gf_dbl(a1 ^ a2) ^ a0 ^ a2 ^ a3;
          t[4*c+2] = gf_dbl(a2 ^ a3) ^ a0 ^ a1 ^ a3;
          t[4*c+3] = gf_dbl(a3 ^ a0) ^ a0 ^ a1 ^ a2;
        end
      end
      for (int i = 0; i < 16; i++) s[127-8*i -: 8] = t[i];
      s ^= rkey(r);
    end
    return s;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] s, input int nr);
    logic [7:0] b [16];
    logic [7:0] a0, a1, a2, a3;
    s ^= rkey(nr);
    for (int r = nr - 1; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) b[w+4*((c+w)%4)] = s[127-8*(w+4*c) -: 8];
      for (int i = 0; i < 16; i++) s[127-8*i -: 8] = inv_tab[b[i]];
      s ^= rkey(r);
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[127-8*(4*c) -: 8];   a1 = s[127-8*(4*c+1) -: 8];
          a2 = s[127-8*(4*c+2) -: 8]; a3 = s[127-8*(4*c+3) -: 8];
          s[127-8*(4*c) -: 8]   = gf_mul(a0,14) ^ gf_mul(a1,11) ^ gf_mul(a2,13) ^ gf_mul(a3,9);
          s[127-8*(4*c+1) -: 8] = gf_mul(a0,9) ^ gf_mul(a1,14) ^ gf_mul(a2,11) ^ gf_mul(a3,13);
          s[127-8*(4*c+2) -: 8] = gf_mul(a0,13) ^ gf_mul(a1,9) ^ gf_mul(a2,14) ^ gf_mul(a3,11);
          s[127-8*(4*c+3) -: 8] = gf_mul(a0,11) ^ gf_mul(a1,13) ^ gf_mul(a2,9) ^ gf_mul(a3,14);
        end
      end
    end
    return s;
  endfunction

  // expected result for one accepted block, advancing chain and counter
  function automatic block_t cipher_predict(input logic [63:0] hi, input logic [63:0] lo,
                                            input logic [4:0] nv_in, input logic first);
    logic [127:0] blk, ks;
    logic [63:0]  ctr_rev;
    logic [1:0]   kind;
    logic         dec;
    int           nv, nr;
    dec  = m_mode[0];
    kind = (m_mode[2:1] == 2'd3) ? KIND_ECB : m_mode[2:1];
    nv   = (nv_in > 16) ? 16 : nv_in;
    if (first) begin
      m_chain_hi = m_iv_hi;
      m_chain_lo = m_iv_lo;
      m_counter  = '0;
    end
    blk = {hi, lo};
    if (!dec)
      for (int i = nv; i < 16; i++) blk[127-8*i -: 8] = 8'h00;
    nr = build_schedule();
    case (kind)
      KIND_CBC: begin
        if (!dec) begin
          blk = aes_encrypt(blk ^ {m_chain_hi, m_chain_lo}, nr);
          {m_chain_hi, m_chain_lo} = blk;
        end else begin
          blk = aes_decrypt(blk, nr) ^ {m_chain_hi, m_chain_lo};
          {m_chain_hi, m_chain_lo} = {hi, lo};
        end
      end
      KIND_CTR: begin
        // counter goes in least significant byte first
        ctr_rev = {<<8{m_counter}};
        ks = aes_encrypt({m_iv_hi, ctr_rev}, nr);
        blk ^= ks;
        m_counter = m_counter + 64'd1;
      end
      default: blk = dec ? aes_decrypt(blk, nr) : aes_encrypt(blk, nr);
    endcase
    return blk;
  endfunction

  // ---- result checker ----
  always @(posedge clk) begin
    block_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result %h %h", result_high, result_low);
      end else begin
        want = pending_results.pop_front();
        if (result_high !== want.hi || result_low !== want.lo) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result mismatch: expected %h %h, got %h %h",
                     want.hi, want.lo, result_high, result_low);
        end
      end
    end
  end

  // ---- receiver stalls ----
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // ---- sender: one item, called at a falling edge ----
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] nv, input logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    block_high  = hi;
    block_low   = lo;
    bytes_valid = nv;
    first_block = first;
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(cipher_predict(hi, lo, nv, first));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // register write through the config port, only while idle
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_IVH:  m_iv_hi = val;
      REG_IVL:  m_iv_lo = val;
      REG_KLEN: m_klen  = val[1:0];
      REG_MODE: m_mode  = val[2:0];
      default:  m_key[idx[1:0]] = val;
    endcase
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---- directed: field extremes, every mode, odd codes ----
  task automatic test_directed();
    write_reg(REG_KEY0, 64'h0001020304050607);
    write_reg(REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_reg(REG_KEY2, 64'h1011121314151617);
    write_reg(REG_KEY3, 64'h18191a1b1c1d1e1f);
    write_reg(REG_IVH,  64'hffffffffffffffff);
    write_reg(REG_IVL,  64'h0123456789abcdef);
    write_reg(REG_KLEN, KLEN_128);
    write_reg(REG_MODE, MODE_ECB_ENC);
    send_block('0, '0, 5'd16, 1'b1);
    send_block('1, '1, 5'd16, 1'b0);
    send_block('1, '1, 5'd0,  1'b0);   // everything zeroed
    send_block('1, '1, 5'd1,  1'b0);
    send_block('1, '1, 5'd17, 1'b0);   // over 16 acts as 16
    send_block('1, '1, 5'd31, 1'b0);
    write_reg(REG_MODE, MODE_ECB_DEC);
    send_block('1, '1, 5'd0,  1'b0);   // length ignored on decrypt
    write_reg(REG_MODE, MODE_CBC_ENC);
    send_block(64'h00112233_44556677, 64'h8899aabb_ccddeeff, 5'd16, 1'b1);
    send_block('1, '0, 5'd8, 1'b0);
    write_reg(REG_MODE, MODE_CBC_DEC);
    send_block(64'hdeadbeef_00000000, '1, 5'd3, 1'b1);
    send_block('0, '1, 5'd16, 1'b0);
    write_reg(REG_MODE, MODE_CTR_ENC);
    send_block('1, '1, 5'd16, 1'b1);
    send_block('1, '1, 5'd3,  1'b0);
    send_block('0, '0, 5'd16, 1'b1);
    write_reg(REG_MODE, MODE_CTR_DEC);
    send_block('1, '0, 5'd0, 1'b1);
    send_block('0, '1, 5'd9, 1'b0);
    write_reg(REG_MODE, MODE_ALT_ENC);
    send_block('1, '1, 5'd5, 1'b0);
    write_reg(REG_MODE, MODE_ALT_DEC);
    send_block('1, '1, 5'd5, 1'b0);
    write_reg(REG_MODE, MODE_ECB_ENC);
    write_reg(REG_KLEN, KLEN_192);
    send_block('0, '0, 5'd16, 1'b0);
    write_reg(REG_KLEN, KLEN_256);
    send_block('0, '0, 5'd16, 1'b0);
    write_reg(REG_KLEN, KLEN_ALIAS);
    send_block('0, '0, 5'd16, 1'b0);
  endtask

  // ---- random: settings, then a chained message of random blocks ----
  task automatic test_random_messages(input int n_blocks);
    int sent, len;
    logic [63:0] hi, lo;
    logic [4:0]  nv;
    sent = 0;
    while (sent < n_blocks) begin
      for (int r = 0; r < 6; r++) write_reg(3'(r), rand_word());
      write_reg(REG_KLEN, 2'($urandom_range(3)));
      write_reg(REG_MODE, 3'($urandom_range(7)));
      len = $urandom_range(4, 40);
      for (int k = 0; k < len; k++) begin
        hi = rand_word();
        lo = rand_word();
        nv = ($urandom_range(99) < 65) ? 5'd16 : 5'($urandom_range(31));
        send_block(hi, lo, nv, (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
      end
      sent += len;
    end
  endtask

  initial begin
    mismatches    = 0;
    send_idle_pct = 18;
    recv_idle_pct = 70;
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    block_high  = '0;
    block_low   = '0;
    bytes_valid = '0;
    first_block = 1'b0;
    out_ready   = 1'b0;
    m_key       = '{default: '0};
    m_iv_hi     = '0;
    m_iv_lo     = '0;
    m_klen      = KLEN_128;
    m_mode      = MODE_ECB_ENC;
    m_chain_hi  = '0;
    m_chain_lo  = '0;
    m_counter   = '0;
    build_sub_tables();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_messages(560);
    send_idle_pct = 70;
    recv_idle_pct = 18;
    test_random_messages(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(560);

    wait_idle();
    if (mismatches == 0) $display("tb_aes_block_mode_engine_core OK");
    else $display("tb_aes_block_mode_engine_core NOT OK");
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("tb_aes_block_mode_engine_core NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hdl/aesm_pkg.sv
hdl/aesm_key_store.sv
hdl/aes_block_mode_engine_core.sv
test/tb_aes_block_mode_engine_core.sv
